// ===== src/pba_pkg.sv =====
// Types and codes shared by the page bitmap allocator.
`timescale 1ns / 1ps
package pba_pkg;

  localparam int CW = 13;  // count and total width
  localparam int PW = 12;  // page index width on the ports
  localparam int MAX_PAGES = 4096;  // bitmap depth, bounded by the port widths

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_NOFIT  = 2'd1,
    STS_BADCNT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_FREE,
    S_OUT
  } state_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [PW-1:0]     page_start;
    logic [CW-1:0]     page_count;
  } in_t;

  typedef struct packed {
    status_t           status;
    logic [PW-1:0]     first_page;
    logic [CW-1:0]     used_count;
    logic [CW-1:0]     free_count;
    logic [CW-1:0]     total_count;
  } out_t;

endpackage

// ===== src/page_bitmap_allocator.sv =====
// Top level: next-fit page allocator over a one-bit-per-page bitmap memory.
// Allocate scans the bitmap one page per cycle through a registered-read RAM.
// Free clears the pages of its range (clipped at the page total).
// One command at a time; in_stall stays high until the result beat is taken.
// Reset and every page total write sweep the whole bitmap, setting all bits used.
`timescale 1ns / 1ps
module page_bitmap_allocator (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pba_pkg::in_t         in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pba_pkg::out_t        out_data,
  input  logic                 cfg_we,
  input  logic [pba_pkg::CW-1:0] cfg_data
);
  import pba_pkg::*;

  localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam logic [CW-1:0] TOT_RST = CW'((MAX_PAGES < 4096) ? MAX_PAGES : 4096);

  logic mem [MAX_PAGES];
  logic rdata_r;

  state_t        state_r, state_nxt;
  logic [CW-1:0] total_r, total_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [CW-1:0] cur_r, cur_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] ia_r, ia_nxt;      // issue address / mark address
  logic [CW-1:0] iss_r, iss_nxt;    // issued reads / pages left to mark
  logic [CW-1:0] pg_r, pg_nxt;      // page of data in rdata_r
  logic [CW-1:0] evc_r, evc_nxt;    // pages evaluated
  logic [CW-1:0] len_r, len_nxt;
  logic [CW:0]   end_r, end_nxt;
  logic          pend_r, pend_nxt;
  status_t       sts_r, sts_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] clr_r, clr_nxt;

  logic          we, wdata;
  logic [AW-1:0] waddr, raddr;

  logic          in_acc, clr_done, scan_hit, scan_fail, free_done, mark_done;
  logic [CW-1:0] len_base, cfg_tot;
  logic [CW:0]   free_end;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign clr_done  = (clr_r == AW'(MAX_PAGES - 1));
  assign len_base  = (pg_r == '0) ? '0 : len_r;
  assign scan_hit  = pend_r && !rdata_r && (len_base + 1'b1 == cnt_r);
  assign scan_fail = pend_r && !scan_hit && (evc_r + 1'b1 == total_r);
  assign free_done = pend_r && ({1'b0, pg_r} + 1'b1 == end_r);
  assign mark_done = (iss_r == CW'(1));
  assign free_end  = ({1'b0, in_data.page_count} + (CW+1)'(in_data.page_start) >
                      {1'b0, total_r}) ? {1'b0, total_r}
                     : {1'b0, in_data.page_count} + (CW+1)'(in_data.page_start);
  assign cfg_tot   = (cfg_data == '0) ? CW'(1)
                     : ((32'(cfg_data) > MAX_PAGES) ? CW'(MAX_PAGES) : cfg_data);

  assign out_data.status      = sts_r;
  assign out_data.first_page  = idx_r[PW-1:0];
  assign out_data.used_count  = used_r;
  assign out_data.free_count  = total_r - used_r;
  assign out_data.total_count = total_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_done) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.cmd == CMD_ALLOC) begin
            if (in_data.page_count == '0 || in_data.page_count > total_r) state_nxt = S_OUT;
            else state_nxt = S_SCAN;
          end else begin
            if (in_data.page_count == '0 || CW'(in_data.page_start) >= total_r)
              state_nxt = S_OUT;
            else state_nxt = S_FREE;
          end
        end
      end
      S_SCAN: begin
        if (scan_hit) state_nxt = S_MARK;
        else if (scan_fail) state_nxt = S_OUT;
      end
      S_MARK: if (mark_done) state_nxt = S_OUT;
      S_FREE: if (free_done) state_nxt = S_OUT;
      S_OUT:  if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    if (cfg_we) state_nxt = S_CLEAR;
  end

  // datapath and memory control
  always_comb begin
    total_nxt = total_r;
    used_nxt  = used_r;
    cur_nxt   = cur_r;
    cnt_nxt   = cnt_r;
    ia_nxt    = ia_r;
    iss_nxt   = iss_r;
    pg_nxt    = pg_r;
    evc_nxt   = evc_r;
    len_nxt   = len_r;
    end_nxt   = end_r;
    pend_nxt  = 1'b0;
    sts_nxt   = sts_r;
    idx_nxt   = idx_r;
    clr_nxt   = clr_r;
    we        = 1'b0;
    wdata     = 1'b1;
    waddr     = AW'(ia_r);
    raddr     = AW'(ia_r);
    unique case (state_r)
      S_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        clr_nxt = clr_r + 1'b1;
      end
      S_IDLE: begin
        cnt_nxt = in_data.page_count;
        iss_nxt = '0;
        evc_nxt = '0;
        len_nxt = '0;
        idx_nxt = '0;
        sts_nxt = STS_OK;
        end_nxt = free_end;
        if (in_data.cmd == CMD_ALLOC) begin
          ia_nxt = cur_r;
          if (in_data.page_count == '0 || in_data.page_count > total_r) sts_nxt = STS_BADCNT;
        end else begin
          ia_nxt = CW'(in_data.page_start);
          if (in_data.page_count == '0) sts_nxt = STS_BADCNT;
        end
      end
      S_SCAN: begin
        if (iss_r < total_r) begin
          pend_nxt = 1'b1;
          pg_nxt   = ia_r;
          iss_nxt  = iss_r + 1'b1;
          ia_nxt   = (ia_r + 1'b1 == total_r) ? '0 : ia_r + 1'b1;
        end
        if (pend_r) begin
          evc_nxt = evc_r + 1'b1;
          len_nxt = rdata_r ? '0 : len_base + 1'b1;
        end
        if (scan_hit) begin
          used_nxt = used_r + cnt_r;
          cur_nxt  = (pg_r + 1'b1 == total_r) ? '0 : pg_r + 1'b1;
          idx_nxt  = pg_r - cnt_r + 1'b1;
          ia_nxt   = pg_r;
          iss_nxt  = cnt_r;
          pend_nxt = 1'b0;
        end else if (scan_fail) begin
          sts_nxt = STS_NOFIT;
        end
      end
      S_MARK: begin
        we      = 1'b1;
        ia_nxt  = ia_r - 1'b1;
        iss_nxt = iss_r - 1'b1;
      end
      S_FREE: begin
        if ({1'b0, ia_r} < end_r) begin
          pend_nxt = 1'b1;
          pg_nxt   = ia_r;
          ia_nxt   = ia_r + 1'b1;
        end
        if (pend_r && rdata_r) begin
          we       = 1'b1;
          wdata    = 1'b0;
          waddr    = AW'(pg_r);
          used_nxt = used_r - 1'b1;
          if (pg_r < cur_r) cur_nxt = pg_r;
        end
      end
      S_OUT: ;
      default: ;
    endcase
    if (cfg_we) begin
      total_nxt = cfg_tot;
      used_nxt  = cfg_tot;
      cur_nxt   = '0;
      clr_nxt   = '0;
      pend_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      total_r <= TOT_RST;
      used_r  <= TOT_RST;
      cur_r   <= '0;
      clr_r   <= '0;
      pend_r  <= 1'b0;
      sts_r   <= STS_OK;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      used_r  <= used_nxt;
      cur_r   <= cur_nxt;
      clr_r   <= clr_nxt;
      pend_r  <= pend_nxt;
      sts_r   <= sts_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    ia_r  <= ia_nxt;
    iss_r <= iss_nxt;
    pg_r  <= pg_nxt;
    evc_r <= evc_nxt;
    len_r <= len_nxt;
    end_r <= end_nxt;
    idx_r <= idx_nxt;
  end

  a_used_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= total_r) else $error("used count above total");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (cur_r < total_r)) else $error("cursor out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall && !cfg_we) |=> out_valid) else $error("result beat dropped");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_OUT) |-> !we) else $error("bitmap write while idle");

endmodule

// ===== dv/page_bitmap_allocator_checker.sv =====
// Checker for the page allocator: tracks the bitmap, predicts each result and compares it.
`timescale 1ns / 1ps
module page_bitmap_allocator_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  pba_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  pba_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [pba_pkg::CW-1:0] cfg_data,
  output int            fail_count,
  output int            pending,
  output int            checked,
  output int            nofit_seen,
  output int            frees_seen
);
  import pba_pkg::*;

  localparam int NPAGES = 4096;

  bit     page_used [NPAGES];
  int     used_tally;
  int     cursor;
  int     total;
  out_t   expected_q[$];

  function automatic bit claim_run(int lo, int hi, int cnt, output int first);
    int pos;
    int len;
    pos = lo;
    first = 0;
    while (pos + cnt <= hi) begin
      len = 0;
      while (pos + len < hi && len < cnt && !page_used[pos + len]) len++;
      if (len == cnt) begin
        for (int k = 0; k < cnt; k++) page_used[pos + k] = 1'b1;
        used_tally += cnt;
        cursor = (pos + cnt) % total;
        first = pos;
        return 1'b1;
      end
      pos += len + 1;
    end
    return 1'b0;
  endfunction

  function automatic out_t predict_command(in_t cmd_in);
    out_t    res;
    status_t sts;
    int      first;
    int      cnt;
    int      p;
    int      cur;
    bit      done;
    cnt = int'(cmd_in.page_count);
    first = 0;
    done = 1'b0;
    if (cmd_in.cmd == CMD_ALLOC) begin
      if (cnt == 0 || cnt > total) begin
        sts = STS_BADCNT;
      end else if (cnt == 1) begin
        sts = STS_NOFIT;
        for (int n = 0; n < total && !done; n++) begin
          p = (cursor + n) % total;
          if (!page_used[p]) begin
            page_used[p] = 1'b1;
            used_tally++;
            cursor = (p + 1) % total;
            first = p;
            sts = STS_OK;
            done = 1'b1;
          end
        end
      end else begin
        cur = cursor;
        if (claim_run(cur, total, cnt, first)) sts = STS_OK;
        else if (cur > 0 && claim_run(0, cur, cnt, first)) sts = STS_OK;
        else sts = STS_NOFIT;
      end
    end else begin
      if (cnt == 0) begin
        sts = STS_BADCNT;
      end else begin
        sts = STS_OK;
        for (int k = 0; k < cnt; k++) begin
          p = int'(cmd_in.page_start) + k;
          if (p >= total) break;
          if (page_used[p]) begin
            page_used[p] = 1'b0;
            used_tally--;
            if (p < cursor) cursor = p;
          end
        end
      end
    end
    if (sts != STS_OK) first = 0;
    res.status      = sts;
    res.first_page  = first[PW-1:0];
    res.used_count  = used_tally[CW-1:0];
    res.free_count  = CW'(total - used_tally);
    res.total_count = total[CW-1:0];
    return res;
  endfunction

  function automatic void mark_everything_used(int v);
    total = (v == 0) ? 1 : (v > NPAGES) ? NPAGES : v;
    for (int i = 0; i < NPAGES; i++) page_used[i] = 1'b1;
    used_tally = total;
    cursor = 0;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
    checked = 0;
    nofit_seen = 0;
    frees_seen = 0;
    mark_everything_used(NPAGES);
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      mark_everything_used(NPAGES);
      expected_q.delete();
    end else begin
      if (cfg_we) mark_everything_used(int'(cfg_data));
      if (in_valid && !in_stall) begin
        if (in_data.cmd == CMD_FREE) frees_seen++;
        expected_q.push_back(predict_command(in_data));
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result beat: %p", out_data);
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (want.status == STS_NOFIT) nofit_seen++;
          if (out_data.status !== want.status || out_data.first_page !== want.first_page ||
              out_data.used_count !== want.used_count ||
              out_data.free_count !== want.free_count ||
              out_data.total_count !== want.total_count) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected %p got %p", want, out_data);
          end
        end
      end
    end
    pending = expected_q.size();
  end
endmodule

// ===== dv/page_bitmap_allocator_test.sv =====
// Testbench top: clock, reset, stimulus and verdict for the page allocator.
`timescale 1ns / 1ps
module page_bitmap_allocator_test;
  import pba_pkg::*;

  localparam int IDLE_LIMIT = 60000;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  in_t           in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  out_t          out_data;
  logic          cfg_we = 1'b0;
  logic [CW-1:0] cfg_data = '0;

  int   fail_count, pending, checked, nofit_seen, frees_seen;
  int   snd_pct = 0;
  int   rcv_pct = 0;
  int   idle_cycles = 0;
  int   settings_done = 0;
  logic hold = 1'b0;
  bit   hold_req = 1'b0;

  always #5 clk = ~clk;

  page_bitmap_allocator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  page_bitmap_allocator_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .checked(checked),
    .nofit_seen(nofit_seen), .frees_seen(frees_seen)
  );

  always @(posedge clk) begin
    out_stall <= hold || ($urandom_range(99) < rcv_pct);
  end

  // Long receiver hold-off so the block backs up its input.
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold <= 1'b1;
    repeat (700) @(posedge clk);
    hold <= 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
      $display("page_bitmap_allocator_test NOT OK");
      $finish;
    end
  end

  task automatic send(cmd_t c, int start, int cnt);
    if (snd_pct > 0 && $urandom_range(99) < snd_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.cmd <= c;
    in_data.page_start <= start[PW-1:0];
    in_data.page_count <= cnt[CW-1:0];
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_total(int v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v[CW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_done++;
  endtask

  task automatic random_item(int t);
    int r;
    int lim;
    r = $urandom_range(99);
    lim = (t / 4 > 1) ? t / 4 : 1;
    if (r < 35)      send(CMD_ALLOC, $urandom, $urandom_range(1, lim));
    else if (r < 48) send(CMD_ALLOC, $urandom, 1);
    else if (r < 80) send(CMD_FREE, $urandom_range(0, t - 1), $urandom_range(1, lim));
    else if (r < 85) send(CMD_FREE, $urandom_range(0, 4095), $urandom_range(0, 8191));
    else if (r < 89) send(CMD_ALLOC, 0, $urandom_range(0, 8191));
    else if (r < 92) send(cmd_t'($urandom_range(1)), $urandom, 0);
    else if (r < 96) send(CMD_ALLOC, 0, t + $urandom_range(0, 1));
    else             send(CMD_FREE, $urandom_range(0, t), t);
  endtask

  initial begin
    int totals[8];
    int t;
    int n;
    totals = '{1, 0, 8191, 37, 64, 200, 13, 4096};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: everything used after reset, then the edge cases.
    send(CMD_ALLOC, 0, 1);
    send(CMD_ALLOC, 0, 0);
    send(CMD_ALLOC, 0, 4097);
    send(CMD_ALLOC, 4095, 8191);
    send(CMD_FREE, 0, 0);
    send(CMD_FREE, 0, 4096);
    send(CMD_ALLOC, 0, 4096);
    send(CMD_FREE, 4095, 1);
    send(CMD_FREE, 4095, 8191);
    send(CMD_ALLOC, 0, 1);
    send(CMD_FREE, 100, 50);
    send(CMD_FREE, 100, 50);
    send(CMD_ALLOC, 0, 30);
    send(CMD_ALLOC, 0, 30);
    send(CMD_ALLOC, 0, 1);
    send(CMD_FREE, 0, 1);
    send(CMD_ALLOC, 0, 1);
    set_total(1);
    send(CMD_ALLOC, 0, 1);
    send(CMD_FREE, 0, 1);
    send(CMD_ALLOC, 0, 1);
    send(CMD_ALLOC, 0, 2);
    send(CMD_FREE, 4095, 1);

    for (int ph = 0; ph < 8; ph++) begin
      set_total(totals[ph]);
      t = (totals[ph] == 0) ? 1 : (totals[ph] > 4096) ? 4096 : totals[ph];
      case (ph % 4)
        0: begin snd_pct = 0;  rcv_pct = 0;  end
        1: begin snd_pct = 55; rcv_pct = 0;  end
        2: begin snd_pct = 0;  rcv_pct = 55; end
        default: begin snd_pct = 33; rcv_pct = 33; end
      endcase
      n = (t >= 4096) ? 20 : 55;
      // open up the map before random traffic
      send(CMD_FREE, $urandom_range(0, t - 1), t);
      for (int i = 0; i < n; i++) begin
        if (ph == 3 && i == 10) hold_req = 1'b1;
        if (ph == 4 && i == n / 2) drain();
        random_item(t);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d commands (%0d frees, %0d no-fit) over %0d page total settings",
             checked, frees_seen, nofit_seen, settings_done);
    if (fail_count == 0) begin
      $display("page_bitmap_allocator_test OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("page_bitmap_allocator_test NOT OK");
    end
    $finish;
  end
endmodule

// ===== page_bitmap_allocator.f =====
src/pba_pkg.sv
src/page_bitmap_allocator.sv
dv/page_bitmap_allocator_checker.sv
dv/page_bitmap_allocator_test.sv
